[rtl/mdc_pkg.sv]
package mdc_pkg;

	// Motion states, also used as the reported state code
	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_FORWARD  = 3'd1,
		ST_BACKWARD = 3'd2,
		ST_STOP     = 3'd3,
		ST_STANDBY  = 3'd4
	} motion_t;

	// Remote command codes
	typedef enum logic [2:0] {
		CMD_NONE     = 3'd0,
		CMD_FORWARD  = 3'd1,
		CMD_BACKWARD = 3'd2,
		CMD_STOP     = 3'd3,
		CMD_STANDBY  = 3'd4
	} cmd_t;

	// Register indexes (word address)
	typedef enum logic [1:0] {
		REG_RUN_DUTY     = 2'd0,
		REG_PRESS_LOCK   = 2'd1,
		REG_RUN_TIMEOUT  = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	localparam int TICK_W = 16;
	localparam int DUTY_W = 8;

	localparam logic [TICK_W-1:0] TICK_MAX            = '1;
	localparam logic [DUTY_W-1:0] RUN_DUTY_RESET      = 8'd250;
	localparam logic [TICK_W-1:0] PRESS_LOCKOUT_RESET = 16'd300;
	localparam logic [TICK_W-1:0] RUN_TIMEOUT_RESET   = 16'd30000;

	// Button cycle positions
	localparam logic [1:0] BTN_NEXT_FWD  = 2'd0;
	localparam logic [1:0] BTN_NEXT_BWD  = 2'd1;
	localparam logic [1:0] BTN_NEXT_STOP = 2'd2;

	// Saturating tick increment
	function automatic logic [TICK_W-1:0] tick_inc(input logic [TICK_W-1:0] t);
		tick_inc = (t == TICK_MAX) ? t : t + 1'b1;
	endfunction

endpackage

[rtl/motor_direction_controller.sv]
// Motor direction controller, one input transfer per millisecond tick.
// Input stream (s_*): each transfer is one tick carrying an optional remote
// command and the button level. Output stream (m_*): exactly one result per
// tick with the motion state, sleep/phase/duty pin levels and a report flag.
// The user must write the APB registers (run duty, press lockout, run
// timeout) only while no tick is in flight; the block does not enforce it.
// The result appears in the cycle after the input transfer, held in the
// output register. Throughput: one tick per cycle; the whole state
// update is a single pass of compare and select logic feeding the state and
// output registers, so s_tready stays high while the output register is
// empty or being taken in the same cycle.
// When the receiver stalls, the result holds in the output register and
// s_tready drops until it is taken; no result is dropped or repeated.
// Reset puts the motor in standby with the driver asleep, duty zero, all
// counters cleared and the registers at their defaults.
module motor_direction_controller
	import mdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input tick stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] cmd, [3] button_pressed
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [2:0] run_state, [3] driver_awake,
	                               // [4] phase_forward, [12:5] pwm_duty,
	                               // [13] report_state
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [DUTY_W-1:0] run_duty_q;
	logic [TICK_W-1:0] press_lockout_q;
	logic [TICK_W-1:0] run_timeout_q;

	// controller state
	motion_t           state_q;
	logic              phase_q;
	logic              awake_q;
	logic [DUTY_W-1:0] duty_q;
	logic [TICK_W-1:0] run_ticks_q;
	logic [TICK_W-1:0] press_ticks_q;
	logic              latch_q;
	logic [1:0]        cycle_q;
	motion_t           last_rep_q;

	// output register
	logic              m_valid_q;
	logic [15:0]       m_data_q;

	// next-state values
	motion_t           state_d;
	logic              phase_d;
	logic              awake_d;
	logic [DUTY_W-1:0] duty_d;
	logic [TICK_W-1:0] run_ticks_d;
	logic [TICK_W-1:0] press_ticks_d;
	logic              latch_d;
	logic [1:0]        cycle_d;
	logic              changed;
	logic              report;
	logic              press_ok;
	logic              in_xfer;
	logic              cfg_wr;
	cmd_t              cmd;
	logic              pressed;
	reg_idx_t          reg_idx;

	assign cmd      = cmd_t'(s_tdata[2:0]);
	assign pressed  = s_tdata[3];
	assign s_tready = !m_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// APB access
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_RUN_DUTY:    prdata = {{(32-DUTY_W){1'b0}}, run_duty_q};
			REG_PRESS_LOCK:  prdata = {{(32-TICK_W){1'b0}}, press_lockout_q};
			REG_RUN_TIMEOUT: prdata = {{(32-TICK_W){1'b0}}, run_timeout_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_duty_q      <= RUN_DUTY_RESET;
			press_lockout_q <= PRESS_LOCKOUT_RESET;
			run_timeout_q   <= RUN_TIMEOUT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_RUN_DUTY:    run_duty_q      <= pwdata[DUTY_W-1:0];
				REG_PRESS_LOCK:  press_lockout_q <= pwdata[TICK_W-1:0];
				REG_RUN_TIMEOUT: run_timeout_q   <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// one tick: command, then button, then run timeout
	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		awake_d       = awake_q;
		duty_d        = duty_q;
		run_ticks_d   = tick_inc(run_ticks_q);
		press_ticks_d = tick_inc(press_ticks_q);
		latch_d       = latch_q;
		cycle_d       = cycle_q;
		changed       = 1'b0;

		// remote command
		case (cmd) inside
			CMD_FORWARD, CMD_BACKWARD: begin
				awake_d     = 1'b1;
				phase_d     = (cmd == CMD_FORWARD);
				duty_d      = run_duty_q;
				run_ticks_d = '0;
				state_d     = (cmd == CMD_FORWARD) ? ST_FORWARD : ST_BACKWARD;
				changed     = 1'b1;
			end
			CMD_STOP: begin
				cycle_d     = BTN_NEXT_FWD;
				awake_d     = 1'b1;
				duty_d      = '0;
				run_ticks_d = '0;
				state_d     = ST_STOP;
				changed     = 1'b1;
			end
			CMD_STANDBY: begin
				cycle_d     = BTN_NEXT_FWD;
				awake_d     = 1'b0;
				duty_d      = '0;
				run_ticks_d = '0;
				state_d     = ST_STANDBY;
				changed     = 1'b1;
			end
			default: ;
		endcase

		// button: lockout strictly passed and released since last press
		press_ok = pressed && (press_ticks_d > press_lockout_q) && !latch_q;
		if (press_ok) begin
			press_ticks_d = '0;
			latch_d       = 1'b1;
			run_ticks_d   = '0;
			awake_d       = 1'b1;
			changed       = 1'b1;
			if (cycle_d == BTN_NEXT_FWD) begin
				cycle_d = BTN_NEXT_BWD;
				phase_d = 1'b1;
				duty_d  = run_duty_q;
				state_d = ST_FORWARD;
			end else if (cycle_d == BTN_NEXT_BWD) begin
				cycle_d = BTN_NEXT_STOP;
				phase_d = 1'b0;
				duty_d  = run_duty_q;
				state_d = ST_BACKWARD;
			end else begin
				cycle_d = BTN_NEXT_FWD;
				duty_d  = '0;
				state_d = ST_STOP;
			end
		end else if (!pressed) begin
			latch_d = 1'b0;
		end

		// hard run timeout
		if ((state_d == ST_FORWARD || state_d == ST_BACKWARD) &&
		    run_ticks_d >= run_timeout_q) begin
			cycle_d     = BTN_NEXT_FWD;
			awake_d     = 1'b0;
			duty_d      = '0;
			run_ticks_d = '0;
			state_d     = ST_STANDBY;
			changed     = 1'b1;
		end

		report = changed || (state_d != last_rep_q);
	end

	// state registers, updated once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_STANDBY;
			phase_q       <= 1'b0;
			awake_q       <= 1'b0;
			duty_q        <= '0;
			run_ticks_q   <= '0;
			press_ticks_q <= '0;
			latch_q       <= 1'b0;
			cycle_q       <= BTN_NEXT_FWD;
			last_rep_q    <= ST_NONE;
		end else if (in_xfer) begin
			state_q       <= state_d;
			phase_q       <= phase_d;
			awake_q       <= awake_d;
			duty_q        <= duty_d;
			run_ticks_q   <= run_ticks_d;
			press_ticks_q <= press_ticks_d;
			latch_q       <= latch_d;
			cycle_q       <= cycle_d;
			if (report) begin
				last_rep_q <= state_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_xfer) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			m_data_q <= {2'b00, report, duty_d, phase_d, awake_d, state_d};
		end
	end

endmodule
